### rtl/core/hpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WORD_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HTTP_PORT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_OFFSET  = 3'd6;
  localparam int unsigned CFG_DATA_W = 64;

  // register reset values
  localparam logic [15:0] HTTP_PORT_RESET    = 16'd80;
  localparam logic [7:0]  MATCH_OFFSET_RESET = 8'd22;
  localparam logic [7:0]  MIN_MATCH_OFFSET   = 8'd13;

  // header constants
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam int unsigned PROTO_POS   = 9;
  localparam int unsigned PORT_HI_OFS = 2;
  localparam int unsigned PORT_LO_OFS = 3;
  localparam int unsigned DOFF_OFS    = 12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        drop;
    logic        is_ipv4_tcp;
    logic [15:0] destination_port;
  } out_item_t;

  // header fields collected so far for the current packet
  typedef struct packed {
    logic [3:0]  ip_version;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  protocol_number;
    logic [5:0]  tcp_header_bytes;
    logic [15:0] port_value;
  } hdr_t;

endpackage

`default_nettype wire

### rtl/core/hpf_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module hpf_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  step,
  input  wire hpf_pkg::in_item_t                     item,
  output logic [$clog2(MAX_PACKET_BYTES+1)-1:0]      pos,
  output logic                                       active,
  output hpf_pkg::hdr_t                              hdr,
  output hpf_pkg::hdr_t                              hdr_next,
  output logic                                       has_payload
);
  import hpf_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] tcp_start;

  assign active    = (pos != POS_W'(MAX_PACKET_BYTES));
  assign tcp_start = POS_W'(hdr.ip_header_bytes);

  always_comb begin
    hdr_next = hdr;
    pos_next = pos;
    if (active) begin
      if (pos == '0) begin
        hdr_next.ip_version      = item.data_byte[7:4];
        hdr_next.ip_header_bytes = {item.data_byte[3:0], 2'b00};
      end
      if (pos == POS_W'(PROTO_POS)) begin
        hdr_next.protocol_number = item.data_byte;
      end
      if (pos == tcp_start + POS_W'(PORT_HI_OFS)) begin
        hdr_next.port_value[15:8] = item.data_byte;
      end
      if (pos == tcp_start + POS_W'(PORT_LO_OFS)) begin
        hdr_next.port_value[7:0] = item.data_byte;
      end
      if (pos == tcp_start + POS_W'(DOFF_OFS)) begin
        hdr_next.tcp_header_bytes = {item.data_byte[7:4], 2'b00};
      end
      pos_next = pos + 1'b1;
    end
  end

  // packet longer than both headers together
  assign has_payload = pos_next > (POS_W'(hdr_next.ip_header_bytes)
                                   + POS_W'(hdr_next.tcp_header_bytes));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hdr <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        pos <= '0;
        hdr <= '0;
      end else begin
        pos <= pos_next;
        hdr <= hdr_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/hpf_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

module hpf_matcher #(
  parameter int unsigned MAX_PACKET_BYTES = 65535,
  parameter int unsigned MAX_TARGET_BYTES = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   step,
  input  wire hpf_pkg::in_item_t                      item,
  input  wire logic [$clog2(MAX_PACKET_BYTES+1)-1:0]  pos,
  input  wire logic                                   active,
  input  wire hpf_pkg::hdr_t                          hdr,
  input  wire logic [5:0]                             tlen,
  input  wire logic [7:0]                             match_offset,
  input  wire logic [MAX_TARGET_BYTES-1:0][7:0]       target,
  output logic                                        matched
);
  import hpf_pkg::*;

  localparam int unsigned POS_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned DW     = (POS_W > 9 ? POS_W : 9) + 1;
  localparam int unsigned TIDX_W = (MAX_TARGET_BYTES > 1) ? $clog2(MAX_TARGET_BYTES) : 1;

  logic [5:0]    matched_count;
  logic          mismatch_seen;
  logic [5:0]    count_next;
  logic          mismatch_next;
  logic [7:0]    off;
  logic [DW-1:0] start;
  logic [DW-1:0] rel;
  logic          in_window;
  logic [7:0]    want;

  assign off   = (match_offset < MIN_MATCH_OFFSET) ? MIN_MATCH_OFFSET : match_offset;
  assign start = DW'(hdr.ip_header_bytes) + DW'(hdr.tcp_header_bytes) + DW'(off);
  // wraps to a large value when pos is still before the start
  assign rel       = DW'(pos) - start;
  assign in_window = active && (rel < DW'(tlen));
  assign want      = target[rel[TIDX_W-1:0]];

  always_comb begin
    count_next    = matched_count;
    mismatch_next = mismatch_seen;
    if (in_window) begin
      if (item.data_byte == want) begin
        count_next = matched_count + 1'b1;
      end else begin
        mismatch_next = 1'b1;
      end
    end
  end

  assign matched = !mismatch_next && (count_next == tlen);

  always_ff @(posedge clk) begin
    if (rst) begin
      matched_count <= '0;
      mismatch_seen <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        matched_count <= '0;
        mismatch_seen <= 1'b0;
      end else begin
        matched_count <= count_next;
        mismatch_seen <= mismatch_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/http_host_packet_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// streaming ipv4/tcp payload filter: packet bytes enter one item per cycle,
// starting at the ip header, and the final byte of each packet yields one
// verdict item (drop, ipv4/tcp flag, tcp destination port). the block takes
// one byte every cycle; an item is parsed and compared against the header
// offsets and the configured target string while it sits in the input
// register, and the output register behind out_valid takes the verdict as its
// final byte leaves. the rate is set only by the output register:
// a final byte waits in the input register while an earlier verdict is still
// held by out_ready low, and every other byte keeps flowing. configuration
// writes are taken at any time but belong to idle periods between packets.
module http_host_packet_filter_core #(
  parameter int unsigned MAX_TARGET_BYTES = 32,
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // packet bytes
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire hpf_pkg::in_item_t              in_item,
  // verdicts
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output hpf_pkg::out_item_t                  out_item,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hpf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hpf_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

  // configuration registers
  logic [5:0]                         target_length;
  logic [MAX_TARGET_BYTES-1:0][7:0]   target;
  logic [15:0]                        http_port;
  logic [7:0]                         match_offset;
  logic                               cfg_we;
  logic [5:0]                         tlen;

  // input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_go;

  // parse and match results
  logic [POS_W-1:0] pos;
  logic             active;
  hdr_t             hdr;
  hdr_t             hdr_next;
  logic             has_payload;
  logic             matched;
  logic             v4tcp;
  out_item_t        verdict;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // target length above the store depth is treated as the full store
  assign tlen = (target_length > 6'(MAX_TARGET_BYTES)) ? 6'(MAX_TARGET_BYTES)
                                                       : target_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= '0;
      target        <= '0;
      http_port     <= HTTP_PORT_RESET;
      match_offset  <= MATCH_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_LENGTH: target_length <= cfg_data[5:0];
        CFG_HTTP_PORT:     http_port     <= cfg_data[15:0];
        CFG_MATCH_OFFSET:  match_offset  <= cfg_data[7:0];
        default: ;
      endcase
      // each target word covers eight bytes, lowest byte first
      for (int k = 0; k < MAX_TARGET_BYTES; k++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_TARGET_WORD_0) + (k >> 3))) begin
          target[k] <= cfg_data[(k & 7) * 8 +: 8];
        end
      end
    end
  end

  // a byte moves on unless it is a final byte and the verdict slot is held
  assign s1_go    = s1_valid && (!s1_item.last_byte || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  hpf_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_go),
    .item       (s1_item),
    .pos        (pos),
    .active     (active),
    .hdr        (hdr),
    .hdr_next   (hdr_next),
    .has_payload(has_payload)
  );

  hpf_matcher #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .MAX_TARGET_BYTES(MAX_TARGET_BYTES)
  ) u_matcher (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_go),
    .item        (s1_item),
    .pos         (pos),
    .active      (active),
    .hdr         (hdr),
    .tlen        (tlen),
    .match_offset(match_offset),
    .target      (target),
    .matched     (matched)
  );

  // verdict from the header fields including this byte
  assign v4tcp = (hdr_next.ip_version == IPV4_VERSION)
                 && (hdr_next.protocol_number == PROTO_TCP);

  assign verdict.drop             = v4tcp && (hdr_next.port_value == http_port)
                                    && has_payload && matched;
  assign verdict.is_ipv4_tcp      = v4tcp;
  assign verdict.destination_port = hdr_next.port_value;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.last_byte) begin
      out_item <= verdict;
    end
  end

  // a dropped packet always carried ipv4/tcp and the configured port
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.drop |-> out_item.is_ipv4_tcp
                                   && (out_item.destination_port == http_port))
    else $error("drop verdict without ipv4/tcp on the http port");

  // a final byte always restarts the packet at position zero
  assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_item.last_byte |=> (pos == '0))
    else $error("byte position not cleared after final byte");

  // the input side only stalls on a final byte blocked by a held verdict
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_item.last_byte && out_valid && !out_ready)
    else $error("input stalled without a held verdict");

  // a new verdict never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(s1_go && s1_item.last_byte))
    else $error("verdict overwritten while held");

endmodule

`default_nettype wire

### sim/http_host_packet_filter_core_test.sv
`timescale 1ns / 1ps

import hpf_pkg::*;

typedef logic [7:0] byte_q_t [$];

// keeps its own copy of the filter registers and the per-packet parse state,
// works out the verdict for each packet and checks verdicts in arrival order
class filter_verdict_board;
  localparam int unsigned PACKET_LIMIT = 65535;
  localparam int unsigned TARGET_LIMIT = 32;

  logic [5:0]  target_len;
  logic [63:0] target_words [4];
  logic [15:0] inspect_port;
  logic [7:0]  payload_ofs;

  logic [15:0] byte_pos;
  logic [3:0]  ip_ver;
  logic [5:0]  ip_hdr_len;
  logic [7:0]  proto;
  logic [5:0]  tcp_hdr_len;
  logic [15:0] dport;
  logic [5:0]  match_cnt;
  logic        mismatch;

  out_item_t   pending_verdicts [$];
  int unsigned failures;
  int unsigned verdicts;
  int unsigned drops;

  function new();
    target_len = '0;
    foreach (target_words[i]) target_words[i] = '0;
    inspect_port = HTTP_PORT_RESET;
    payload_ofs = MATCH_OFFSET_RESET;
    clear_packet();
  endfunction

  function void clear_packet();
    byte_pos = '0;
    ip_ver = '0;
    ip_hdr_len = '0;
    proto = '0;
    tcp_hdr_len = '0;
    dport = '0;
    match_cnt = '0;
    mismatch = 1'b0;
  endfunction

  function int unsigned eff_len();
    return target_len > TARGET_LIMIT ? TARGET_LIMIT : target_len;
  endfunction

  function int unsigned eff_ofs();
    return payload_ofs < MIN_MATCH_OFFSET ? MIN_MATCH_OFFSET : payload_ofs;
  endfunction

  function logic [7:0] target_byte(int unsigned k);
    return target_words[(k >> 3) & 3][(k & 7) * 8 +: 8];
  endfunction

  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TARGET_LENGTH: target_len = data[5:0];
      CFG_TARGET_WORD_0: target_words[0] = data;
      CFG_TARGET_WORD_1: target_words[1] = data;
      CFG_TARGET_WORD_2: target_words[2] = data;
      CFG_TARGET_WORD_3: target_words[3] = data;
      CFG_HTTP_PORT:     inspect_port = data[15:0];
      CFG_MATCH_OFFSET:  payload_ofs = data[7:0];
      default: ;
    endcase
  endfunction

  function void note_byte(in_item_t it);
    int unsigned pos;
    int unsigned start;
    out_item_t   v;
    pos = byte_pos;
    if (pos < PACKET_LIMIT) begin
      if (pos == 0) begin
        ip_ver = it.data_byte[7:4];
        ip_hdr_len = {it.data_byte[3:0], 2'b00};
      end
      if (pos == PROTO_POS) proto = it.data_byte;
      if (pos == ip_hdr_len + PORT_HI_OFS) dport[15:8] = it.data_byte;
      if (pos == ip_hdr_len + PORT_LO_OFS) dport[7:0] = it.data_byte;
      if (pos == ip_hdr_len + DOFF_OFS) tcp_hdr_len = {it.data_byte[7:4], 2'b00};
      start = int'(ip_hdr_len) + int'(tcp_hdr_len) + eff_ofs();
      if (pos >= start && pos - start < eff_len()) begin
        if (it.data_byte == target_byte(pos - start)) match_cnt = match_cnt + 6'd1;
        else mismatch = 1'b1;
      end
      byte_pos = pos + 1;
    end
    if (it.last_byte) begin
      v.is_ipv4_tcp = ip_ver == IPV4_VERSION && proto == PROTO_TCP;
      v.destination_port = dport;
      v.drop = v.is_ipv4_tcp && dport == inspect_port &&
               int'(byte_pos) > int'(ip_hdr_len) + int'(tcp_hdr_len) &&
               !mismatch && match_cnt == eff_len();
      pending_verdicts.push_back(v);
      clear_packet();
    end
  endfunction

  function void check_verdict(out_item_t got);
    out_item_t want;
    if (pending_verdicts.size() == 0) begin
      $error("verdict with none outstanding: drop %0b, is_ipv4_tcp %0b, port %0d",
             got.drop, got.is_ipv4_tcp, got.destination_port);
      failures++;
      return;
    end
    want = pending_verdicts.pop_front();
    verdicts++;
    if (got.drop) drops++;
    if (got.drop !== want.drop) begin
      $error("drop: expected %0b, got %0b", want.drop, got.drop);
      failures++;
    end
    if (got.is_ipv4_tcp !== want.is_ipv4_tcp) begin
      $error("is_ipv4_tcp: expected %0b, got %0b", want.is_ipv4_tcp, got.is_ipv4_tcp);
      failures++;
    end
    if (got.destination_port !== want.destination_port) begin
      $error("destination_port: expected %0d, got %0d",
             want.destination_port, got.destination_port);
      failures++;
    end
  endfunction
endclass

module http_host_packet_filter_core_test;

  // extra drain after the last verdict is back, to leave the pipeline empty
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk;
  logic rst;

  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  filter_verdict_board board = new();

  // idling percentages, and a long verdict hold-off requested by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_request = 0;

  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned settings = 0;

  http_host_packet_filter_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  initial begin
    #6_000_000;
    $display("http_host_packet_filter_core test failed");
    $finish;
  end

  // all handshakes seen at the edge, with values from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_byte(in_item);
      if (out_valid && out_ready) board.check_verdict(out_item);
    end
  end

  // verdict sink: random back-pressure, or a long hold-off when asked for
  initial begin : verdict_sink
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // one packet byte; valid is held with the item unchanged until taken
  task automatic send_byte(input logic [7:0] data, input logic last);
    in_item_t it;
    it.data_byte = data;
    it.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    int unsigned i;
    for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  // lower valid and wait until every verdict is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // every register written; junk in the unused upper bits must be ignored
  task automatic configure(input logic [5:0] len, input logic [15:0] port,
                           input logic [7:0] ofs);
    logic [CFG_DATA_W-1:0] data;
    settle();
    data = {$urandom, $urandom};
    data[5:0] = len;
    write_reg(CFG_TARGET_LENGTH, data);
    write_reg(CFG_TARGET_WORD_0, {$urandom, $urandom});
    write_reg(CFG_TARGET_WORD_1, {$urandom, $urandom});
    write_reg(CFG_TARGET_WORD_2, {$urandom, $urandom});
    write_reg(CFG_TARGET_WORD_3, {$urandom, $urandom});
    data = {$urandom, $urandom};
    data[15:0] = port;
    write_reg(CFG_HTTP_PORT, data);
    data = {$urandom, $urandom};
    data[7:0] = ofs;
    write_reg(CFG_MATCH_OFFSET, data);
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // packet laid out for the current registers: ip header, tcp header, then the
  // target at the match offset into the payload; flip spoils one target byte,
  // and the whole thing is cut back to total bytes
  function automatic byte_q_t make_packet(input logic [3:0] ver, input logic [3:0] ihl_n,
      input logic [7:0] proto, input logic [15:0] dport, input logic [3:0] doff_n,
      input int unsigned total, input int flip);
    byte_q_t pkt;
    int unsigned ihl, body, span, i;
    int k;
    ihl = ihl_n * 4;
    body = ihl + doff_n * 4 + board.eff_ofs();
    span = body + board.eff_len();
    for (i = 0; i < (total > span ? total : span); i++) pkt.push_back(8'($urandom));
    pkt[0] = {ver, ihl_n};
    pkt[PROTO_POS] = proto;
    pkt[ihl + PORT_HI_OFS] = dport[15:8];
    pkt[ihl + PORT_LO_OFS] = dport[7:0];
    pkt[ihl + DOFF_OFS] = {doff_n, 4'($urandom)};
    for (k = 0; k < int'(board.eff_len()); k++) begin
      pkt[body + k] = board.target_byte(k);
      if (k == flip) pkt[body + k] ^= 8'($urandom_range(1, 255));
    end
    while (pkt.size() > total) void'(pkt.pop_back());
    return pkt;
  endfunction

  task automatic random_packet();
    int unsigned kind, pick, hdr, ofs, tlen, total, n;
    int flip;
    logic [3:0] ihl_n, doff_n;
    logic [15:0] port;
    byte_q_t pkt;
    kind = $urandom_range(99);
    pick = $urandom_range(99);
    // mostly standard 20 byte headers, some odd sizes, some empty ones
    if (pick < 60) begin
      ihl_n = 4'd5;
      doff_n = 4'd5;
    end else if (pick < 85) begin
      ihl_n = 4'($urandom);
      doff_n = 4'($urandom);
    end else begin
      ihl_n = 4'd0;
      doff_n = 4'd0;
    end
    hdr = ihl_n * 4 + doff_n * 4;
    ofs = board.eff_ofs();
    tlen = board.eff_len();
    if (kind < 70) begin
      // well-formed http packet, sometimes with a spoilt or cut-off target
      total = hdr + ofs + tlen + $urandom_range(0, 6);
      flip = (tlen != 0 && $urandom_range(3) == 0) ? int'($urandom_range(tlen - 1)) : -1;
      if ($urandom_range(9) == 0) total = hdr + ofs + $urandom_range(tlen);
      port = $urandom_range(9) != 0 ? board.inspect_port : 16'($urandom);
      pkt = make_packet(IPV4_VERSION, ihl_n, PROTO_TCP, port, doff_n, total, flip);
    end else if (kind < 85) begin
      // broken headers and lengths, short packets among them
      total = $urandom_range(1, hdr + ofs + tlen + 4);
      port = $urandom_range(1) != 0 ? board.inspect_port : 16'($urandom);
      pkt = make_packet($urandom_range(2) == 0 ? 4'($urandom) : IPV4_VERSION, ihl_n,
                        $urandom_range(2) == 0 ? 8'($urandom) : PROTO_TCP,
                        port, doff_n, total, -1);
    end else begin
      // plain noise
      n = $urandom_range(1, 40);
      repeat (n) pkt.push_back(8'($urandom));
    end
    send_packet(pkt);
  endtask

  initial begin : stimulus
    int unsigned phase, first_byte, first_verdict;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 82;

    // directed packets on reset registers: a lone final byte, a minimal
    // http packet with empty target, and full headers with no payload
    send_packet('{8'hFF});
    send_packet(make_packet(IPV4_VERSION, 4'd0, PROTO_TCP, 16'd80, 4'd0, 14, -1));
    send_packet(make_packet(IPV4_VERSION, 4'd5, PROTO_TCP, 16'd80, 4'd5, 40, -1));

    // small match offset, four target bytes: hit, spoilt byte, cut-off target,
    // wrong version, wrong protocol, wrong port
    configure(6'd4, 16'd80, 8'd0);
    send_packet(make_packet(IPV4_VERSION, 4'd0, PROTO_TCP, 16'd80, 4'd0, 17, -1));
    send_packet(make_packet(IPV4_VERSION, 4'd0, PROTO_TCP, 16'd80, 4'd0, 17, 2));
    send_packet(make_packet(IPV4_VERSION, 4'd0, PROTO_TCP, 16'd80, 4'd0, 15, -1));
    send_packet(make_packet(4'd6, 4'd0, PROTO_TCP, 16'd80, 4'd0, 17, -1));
    send_packet(make_packet(IPV4_VERSION, 4'd0, 8'd17, 16'd80, 4'd0, 17, -1));
    send_packet(make_packet(IPV4_VERSION, 4'd0, PROTO_TCP, 16'd81, 4'd0, 17, -1));

    // random packets over several register settings and idling patterns
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(6'($urandom_range(1, 8)), 16'd80, 8'($urandom_range(13, 20)));
        1: configure(6'd32, 16'd0, 8'd13);
        2: configure(6'd63, 16'hFFFF, 8'd255);
        3: configure(6'd0, 16'($urandom), 8'd5);
        4: configure(6'($urandom_range(0, 32)), 16'($urandom), 8'($urandom_range(13, 40)));
        default: configure(6'($urandom_range(33, 63)), 16'd443, 8'($urandom_range(0, 12)));
      endcase
      if (phase < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 82;
      end else if (phase < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long verdict hold-off while bytes keep coming, to back up the input
      if (phase == 4) stall_request = 400;
      first_byte = bytes_sent;
      first_verdict = board.verdicts;
      // during the hold-off keep offering until the first verdict gets out
      while (bytes_sent - first_byte < 160 ||
             (phase == 4 && board.verdicts == first_verdict))
        random_packet();
    end

    settle();
    $display("covered %0d packets, %0d bytes, %0d verdicts with %0d drops",
             packets_sent, bytes_sent, board.verdicts, board.drops);
    $display("over %0d register settings, both idling patterns and a long verdict hold-off",
             settings);
    if (board.failures == 0) begin
      $display("http_host_packet_filter_core test passed");
    end else begin
      $display("http_host_packet_filter_core test failed");
    end
    $finish;
  end

endmodule
